@@ design/rlp_list_encoder_assert.svh @@
// Assertion macros shared by the rlp_list_encoder checkers.
// Each expects clk and rst_n in scope.
`ifndef RLP_LIST_ENCODER_ASSERT_SVH
`define RLP_LIST_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define RLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlp_list_encoder: same-cycle check failed");

// Next-cycle implication.
`define RLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlp_list_encoder: next-cycle check failed");

`endif

@@ design/rle_pkg.sv @@
// Shared constants, codes and control/status bundles for the RLP list encoder.
// No dependencies.
package rle_pkg;

  localparam int BUFFER_BYTES = 62;
  localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
  localparam int ADDR_W       = $clog2(BUFFER_BYTES);

  // request commands
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_FIELD  = 2'd1;
  localparam logic [1:0] CMD_LIST   = 2'd2;

  // RLP prefix bases
  localparam logic [7:0] RLP_STR_SHORT  = 8'h80;
  localparam logic [7:0] RLP_STR_LONG   = 8'hB7;
  localparam logic [7:0] RLP_LIST_SHORT = 8'hC0;
  localparam logic [7:0] RLP_LIST_LONG  = 8'hF7;
  localparam int         RLP_SHORT_MAX  = 56;

  // output register source select
  localparam logic [1:0] OSEL_LHDR = 2'd0;
  localparam logic [1:0] OSEL_BODY = 2'd1;
  localparam logic [1:0] OSEL_ERR  = 2'd2;

  typedef struct packed {
    logic       fld_wr;
    logic       fld_clr;
    logic       ovf_set;
    logic       clr_all;
    logic       idx_clr;
    logic       idx_inc;
    logic       lst_wr_hdr;
    logic       lst_wr_copy;
    logic       rd_fld;
    logic       rd_lst;
    logic       out_load;
    logic [1:0] out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic fld_full;
    logic fld_empty;
    logic ovf;
    logic fits;
    logic fhdr_none;
    logic fhdr_last;
    logic cp_last;
    logic lhdr_last;
    logic lst_empty;
    logic bd_last;
    logic slot_free;
  } dp_stat_t;

endpackage

@@ design/rle_dp.sv @@
// Datapath of the RLP list encoder: field and list memories, counters,
// header formation and the output register. Depends on rle_pkg.
module rle_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rle_pkg::dp_cmd_t  cmd,
  output rle_pkg::dp_stat_t stat,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last_byte,
  output logic              out_overflow
);
  import rle_pkg::*;

  logic [7:0]       fld_mem [BUFFER_BYTES];
  logic [7:0]       lst_mem [BUFFER_BYTES];
  logic [7:0]       fld_rd_r;
  logic [7:0]       lst_rd_r;

  logic [CNT_W-1:0] fld_cnt_r, fld_cnt_nxt;
  logic [CNT_W-1:0] lst_cnt_r, lst_cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       first_r, first_nxt;
  logic             ovf_r, ovf_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic [1:0]       fhdr_len;
  logic [1:0]       lhdr_len;
  logic [7:0]       fhdr_byte;
  logic [7:0]       lhdr_byte;
  logic [7:0]       lst_wdata;
  logic [CNT_W+1:0] need;
  logic             fld_short;
  logic             lst_short;

  assign fld_short = fld_cnt_r < CNT_W'(RLP_SHORT_MAX);
  assign lst_short = lst_cnt_r < CNT_W'(RLP_SHORT_MAX);

  // single byte below 0x80 is its own encoding
  always_comb begin
    if (fld_cnt_r == CNT_W'(1) && first_r < RLP_STR_SHORT) fhdr_len = 2'd0;
    else if (fld_short)                                      fhdr_len = 2'd1;
    else                                                     fhdr_len = 2'd2;
  end
  assign lhdr_len = lst_short ? 2'd1 : 2'd2;

  // lengths never exceed 255, so the long form always has one length byte
  always_comb begin
    if (idx_r != '0)    fhdr_byte = 8'(fld_cnt_r);
    else if (fld_short) fhdr_byte = RLP_STR_SHORT + 8'(fld_cnt_r);
    else                fhdr_byte = RLP_STR_LONG + 8'd1;
    if (idx_r != '0)    lhdr_byte = 8'(lst_cnt_r);
    else if (lst_short) lhdr_byte = RLP_LIST_SHORT + 8'(lst_cnt_r);
    else                lhdr_byte = RLP_LIST_LONG + 8'd1;
  end

  assign need = {2'b00, lst_cnt_r} + {{CNT_W{1'b0}}, fhdr_len} + {2'b00, fld_cnt_r};

  assign stat.fld_full  = fld_cnt_r == CNT_W'(BUFFER_BYTES);
  assign stat.fld_empty = fld_cnt_r == '0;
  assign stat.ovf       = ovf_r;
  assign stat.fits      = need <= (CNT_W + 2)'(BUFFER_BYTES);
  assign stat.fhdr_none = fhdr_len == 2'd0;
  assign stat.fhdr_last = idx_r == ({{(CNT_W-2){1'b0}}, fhdr_len} - CNT_W'(1));
  assign stat.cp_last   = idx_r == (fld_cnt_r - CNT_W'(1));
  assign stat.lhdr_last = idx_r == ({{(CNT_W-2){1'b0}}, lhdr_len} - CNT_W'(1));
  assign stat.lst_empty = lst_cnt_r == '0;
  assign stat.bd_last   = idx_r == (lst_cnt_r - CNT_W'(1));
  assign stat.slot_free = !out_valid_r || out_ready;

  assign lst_wdata = cmd.lst_wr_hdr ? fhdr_byte : fld_rd_r;

  always_comb begin
    fld_cnt_nxt = fld_cnt_r;
    lst_cnt_nxt = lst_cnt_r;
    idx_nxt     = idx_r;
    first_nxt   = first_r;
    ovf_nxt     = ovf_r;
    if (cmd.clr_all || cmd.fld_clr) fld_cnt_nxt = '0;
    else if (cmd.fld_wr)            fld_cnt_nxt = fld_cnt_r + CNT_W'(1);
    if (cmd.fld_wr && fld_cnt_r == '0) first_nxt = in_data_byte;
    if (cmd.clr_all)                          lst_cnt_nxt = '0;
    else if (cmd.lst_wr_hdr || cmd.lst_wr_copy) lst_cnt_nxt = lst_cnt_r + CNT_W'(1);
    if (cmd.clr_all)      ovf_nxt = 1'b0;
    else if (cmd.ovf_set) ovf_nxt = 1'b1;
    if (cmd.idx_clr)      idx_nxt = '0;
    else if (cmd.idx_inc) idx_nxt = idx_r + CNT_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_ready) out_valid_nxt = 1'b0;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
      unique case (cmd.out_sel)
        OSEL_LHDR: begin
          out_byte_nxt = lhdr_byte;
          out_last_nxt = stat.lst_empty && stat.lhdr_last;
          out_ovf_nxt  = 1'b0;
        end
        OSEL_BODY: begin
          out_byte_nxt = lst_rd_r;
          out_last_nxt = stat.bd_last;
          out_ovf_nxt  = 1'b0;
        end
        OSEL_ERR: begin
          out_byte_nxt = 8'h00;
          out_last_nxt = 1'b1;
          out_ovf_nxt  = 1'b1;
        end
        default: begin
          out_byte_nxt = 8'h00;
          out_last_nxt = 1'b1;
          out_ovf_nxt  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fld_cnt_r   <= '0;
      lst_cnt_r   <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fld_cnt_r   <= fld_cnt_nxt;
      lst_cnt_r   <= lst_cnt_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r    <= first_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.fld_wr) fld_mem[fld_cnt_r[ADDR_W-1:0]] <= in_data_byte;
    if (cmd.rd_fld) fld_rd_r <= fld_mem[idx_r[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.lst_wr_hdr || cmd.lst_wr_copy) lst_mem[lst_cnt_r[ADDR_W-1:0]] <= lst_wdata;
    if (cmd.rd_lst) lst_rd_r <= lst_mem[idx_r[ADDR_W-1:0]];
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;
  assign out_overflow  = out_ovf_r;

endmodule

@@ design/rle_ctrl.sv @@
// Controller of the RLP list encoder: decodes requests and sequences field
// copies and list emission. Depends on rle_pkg.
module rle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  rle_pkg::dp_stat_t stat,
  output rle_pkg::dp_cmd_t  cmd
);
  import rle_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FHDR  = 3'd1;
  localparam logic [2:0] S_CP_RD = 3'd2;
  localparam logic [2:0] S_CP_WR = 3'd3;
  localparam logic [2:0] S_LHDR  = 3'd4;
  localparam logic [2:0] S_BD_RD = 3'd5;
  localparam logic [2:0] S_BD_OUT = 3'd6;
  localparam logic [2:0] S_ERR   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       take;

  assign in_ready = state_r == S_IDLE;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.out_sel = OSEL_LHDR;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (in_command)
            CMD_APPEND: begin
              if (stat.fld_full) cmd.ovf_set = 1'b1;
              else               cmd.fld_wr  = 1'b1;
            end
            CMD_FIELD: begin
              if (stat.ovf) begin
                cmd.fld_clr = 1'b1;
              end else if (!stat.fits) begin
                cmd.ovf_set = 1'b1;
                cmd.fld_clr = 1'b1;
              end else begin
                cmd.idx_clr = 1'b1;
                state_nxt   = stat.fhdr_none ? S_CP_RD : S_FHDR;
              end
            end
            CMD_LIST: begin
              cmd.idx_clr = 1'b1;
              state_nxt   = stat.ovf ? S_ERR : S_LHDR;
            end
            default: ;
          endcase
        end
      end
      S_FHDR: begin
        cmd.lst_wr_hdr = 1'b1;
        cmd.idx_inc    = 1'b1;
        if (stat.fhdr_last) begin
          cmd.idx_clr = 1'b1;
          if (stat.fld_empty) begin
            cmd.fld_clr = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_CP_RD;
          end
        end
      end
      S_CP_RD: begin
        cmd.rd_fld = 1'b1;
        state_nxt  = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.lst_wr_copy = 1'b1;
        cmd.idx_inc     = 1'b1;
        if (stat.cp_last) begin
          cmd.fld_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_CP_RD;
        end
      end
      S_LHDR: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_LHDR;
          cmd.idx_inc  = 1'b1;
          if (stat.lhdr_last) begin
            cmd.idx_clr = 1'b1;
            if (stat.lst_empty) begin
              cmd.clr_all = 1'b1;
              state_nxt   = S_IDLE;
            end else begin
              state_nxt = S_BD_RD;
            end
          end
        end
      end
      S_BD_RD: begin
        cmd.rd_lst = 1'b1;
        state_nxt  = S_BD_OUT;
      end
      S_BD_OUT: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_BODY;
          cmd.idx_inc  = 1'b1;
          if (stat.bd_last) begin
            cmd.clr_all = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_BD_RD;
          end
        end
      end
      S_ERR: begin
        if (stat.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OSEL_ERR;
          cmd.clr_all  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

@@ design/rlp_list_encoder.sv @@
// RLP list encoder top level: controller plus datapath.
// Depends on rle_pkg, rle_ctrl and rle_dp.
//
// Usage: the input channel takes one request per handshake: append a byte to
// the open field, close the field, or close the list. Appends and rejected
// closes leave in_ready high. A field close of N bytes with an H-byte header
// (H = 0, 1 or 2) holds in_ready low while the header is written and the
// field memory is copied into the list memory, one byte at a time, by a read
// state and then a write state.
// A list close streams the list header (1 or 2 bytes) and then the L stored
// bytes on the output channel; each body byte is first read from the list
// memory and then loaded into the output register. out_last_byte marks the
// final byte. If a field or the list overflowed the buffer, the list close
// yields one result with out_overflow and out_last_byte set and out_byte
// zero.
// A stalled receiver holds the output register and pauses the sequencer; the
// block returns to accepting requests once the final byte is loaded.
// Reset clears the counters, the overflow flag and the output valid flag; the
// memories are not cleared and need no clearing pass.
module rlp_list_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_byte,
  output logic       out_overflow
);
  import rle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  rle_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte),
    .out_overflow  (out_overflow)
  );

endmodule

@@ design/rle_checker.sv @@
// Port-level checker for rlp_list_encoder, attached by bind.
// Depends on rle_pkg and rlp_list_encoder_assert.svh.
`include "rlp_list_encoder_assert.svh"

module rle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_byte,
  input logic       out_overflow
);
  import rle_pkg::*;

  // error result is a single zero byte marked last
  `RLE_ASSERT_IMP(a_err_shape, out_valid && out_overflow, out_last_byte && out_byte == 8'h00)

  // list close always produces output, so the block goes busy
  `RLE_ASSERT_NXT(a_list_busy, in_valid && in_ready && in_command == CMD_LIST, !in_ready)

  // no new request is taken in the middle of an emission
  `RLE_ASSERT_IMP(a_mid_busy, out_valid && !out_last_byte, !in_ready)

  // stalled result holds
  `RLE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last_byte))

endmodule

bind rlp_list_encoder rle_checker u_rle_checker (.*);
